// File: sv/chbd_pkg.sv
`default_nettype none

package chbd_pkg;

	// Width of the chunk size accumulator and data byte counter.
	localparam int COUNT_WIDTH = 32;

	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;

	// Marks a byte that is not a hex digit.
	localparam logic [4:0] HEX_NONE = 5'd16;

	typedef enum logic [2:0] {
		PH_HEADER    = 3'd0,
		PH_SKIP_PRE  = 3'd1,
		PH_SIZE      = 3'd2,
		PH_SKIP_POST = 3'd3,
		PH_DATA      = 3'd4,
		PH_DONE      = 3'd5
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       data_valid;
		logic       body_done;
	} out_item_t;

	// Value of a hex digit in either case, or HEX_NONE for any other byte.
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] v;
		v = HEX_NONE;
		if (b >= 8'h30 && b <= 8'h39) begin
			v = 5'(b - 8'h30);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			v = 5'(b - 8'h57);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			v = 5'(b - 8'h37);
		end
		return v;
	endfunction

endpackage

`default_nettype wire

// File: sv/http_chunked_body_decoder.sv
// The result item of an accepted byte item is registered and appears in the cycle after acceptance.
// Throughput: one item per cycle while the receiver does not stall a held result; the decoder state and
// the result register both update at the edge that accepts an item.
// A new item enters at the edge where the held result leaves or the register is empty.
// Reset (arst_n low, asynchronous) returns to header search with a zero count
// and an empty output register; header search with a zero count is restored after each last byte.
`default_nettype none

module http_chunked_body_decoder (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  byte_valid,
	output logic                 byte_stall,
	input  chbd_pkg::in_item_t   byte_data,
	output logic                 body_valid,
	input  wire                  body_stall,
	output chbd_pkg::out_item_t  body_data
);

	localparam int CW = chbd_pkg::COUNT_WIDTH;

	chbd_pkg::phase_t  phase_q, phase_upd, phase_d;
	logic [1:0]        match_q, match_upd, match_d;
	logic [CW-1:0]     count_q, count_upd, count_d;

	logic              accept;
	logic [4:0]        digit;
	logic              is_hex;
	logic              is_crlf;
	logic [CW+3:0]     acc;
	logic [CW-1:0]     acc_sat;
	logic [CW-1:0]     count_dec;

	logic              emit_data;
	logic              done_step;
	chbd_pkg::out_item_t result;

	logic              out_valid_q;
	chbd_pkg::out_item_t out_data_q;

	// An item enters unless a result is held and the receiver stalls it.
	assign byte_stall = out_valid_q & body_stall;
	assign accept     = byte_valid & ~byte_stall;

	// Byte classification and the saturating shift-add of the size.
	assign digit     = chbd_pkg::hex_value(byte_data.in_byte);
	assign is_hex    = (digit != chbd_pkg::HEX_NONE);
	assign is_crlf   = (byte_data.in_byte == chbd_pkg::CH_CR) ||
	                   (byte_data.in_byte == chbd_pkg::CH_LF);
	assign acc       = {count_q, 4'b0000} + {{CW{1'b0}}, digit[3:0]};
	assign acc_sat   = (|acc[CW+3:CW]) ? {CW{1'b1}} : acc[CW-1:0];
	assign count_dec = count_q - {{(CW-1){1'b0}}, 1'b1};

	// Next state from the current phase and the incoming byte.
	always_comb begin
		phase_upd = phase_q;
		match_upd = match_q;
		count_upd = count_q;
		case (phase_q)
			chbd_pkg::PH_HEADER: begin
				if (byte_data.in_byte == (match_q[0] ? chbd_pkg::CH_LF : chbd_pkg::CH_CR)) begin
					if (match_q == 2'd3) begin
						match_upd = 2'd0;
						phase_upd = chbd_pkg::PH_SKIP_PRE;
					end else begin
						match_upd = match_q + 2'd1;
					end
				end else begin
					match_upd = (byte_data.in_byte == chbd_pkg::CH_CR) ? 2'd1 : 2'd0;
				end
			end
			chbd_pkg::PH_SKIP_PRE: begin
				if (!is_crlf) begin
					if (is_hex) begin
						count_upd = {{(CW-4){1'b0}}, digit[3:0]};
						phase_upd = chbd_pkg::PH_SIZE;
					end else begin
						count_upd = '0;
						phase_upd = chbd_pkg::PH_DONE;
					end
				end
			end
			chbd_pkg::PH_SIZE: begin
				if (is_hex) begin
					count_upd = acc_sat;
				end else if (count_q == '0) begin
					phase_upd = chbd_pkg::PH_DONE;
				end else begin
					phase_upd = chbd_pkg::PH_SKIP_POST;
				end
			end
			chbd_pkg::PH_SKIP_POST, chbd_pkg::PH_DATA: begin
				if (!(phase_q == chbd_pkg::PH_SKIP_POST && is_crlf)) begin
					count_upd = count_dec;
					phase_upd = (count_dec == '0) ? chbd_pkg::PH_SKIP_PRE : chbd_pkg::PH_DATA;
				end
			end
			chbd_pkg::PH_DONE: begin
				phase_upd = chbd_pkg::PH_DONE;
			end
			default: begin
				phase_upd = chbd_pkg::PH_DONE;
			end
		endcase

		// The last byte of a response re-arms the decoder.
		if (byte_data.in_last) begin
			phase_d = chbd_pkg::PH_HEADER;
			match_d = 2'd0;
			count_d = '0;
		end else begin
			phase_d = phase_upd;
			match_d = match_upd;
			count_d = count_upd;
		end
	end

	// Result fields for the incoming byte.
	always_comb begin
		emit_data = 1'b0;
		done_step = 1'b0;
		case (phase_q)
			chbd_pkg::PH_SKIP_PRE: begin
				done_step = ~is_crlf & ~is_hex;
			end
			chbd_pkg::PH_SIZE: begin
				done_step = ~is_hex & (count_q == '0);
			end
			chbd_pkg::PH_SKIP_POST: begin
				emit_data = ~is_crlf;
			end
			chbd_pkg::PH_DATA: begin
				emit_data = 1'b1;
			end
			default: begin
				emit_data = 1'b0;
				done_step = 1'b0;
			end
		endcase

		result.out_byte   = emit_data ? byte_data.in_byte : 8'h00;
		result.data_valid = emit_data;
		result.body_done  = done_step |
		                    (byte_data.in_last && phase_upd != chbd_pkg::PH_DONE);
	end

	// Decoder state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= chbd_pkg::PH_HEADER;
			match_q <= 2'd0;
			count_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			match_q <= match_d;
			count_q <= count_d;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!body_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= result;
		end
	end

	assign body_valid = out_valid_q;
	assign body_data  = out_data_q;

endmodule

`default_nettype wire

// File: sv/chbd_checker.sv
`default_nettype none

module chbd_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 byte_valid,
	input wire                 byte_stall,
	input chbd_pkg::in_item_t  byte_data,
	input wire                 body_valid,
	input wire                 body_stall,
	input chbd_pkg::out_item_t body_data
);

	// A stalled result item holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		body_valid && body_stall |=> body_valid && $stable(body_data))
		else $error("stalled result item changed");

	// Every accepted byte item yields a result item on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_stall |=> body_valid)
		else $error("accepted item produced no result");

	// A result item only appears after a byte item was accepted.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(body_valid) |-> $past(byte_valid && !byte_stall))
		else $error("result item without input");

	// With no result held, the input side is never stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		!body_valid |-> !byte_stall)
		else $error("input stalled while output register is empty");

	// Non-data result items carry a zero byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		body_valid && !body_data.data_valid |-> body_data.out_byte == 8'h00)
		else $error("non-data result carries a byte");

endmodule

bind http_chunked_body_decoder chbd_checker u_chbd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.byte_valid (byte_valid),
	.byte_stall (byte_stall),
	.byte_data  (byte_data),
	.body_valid (body_valid),
	.body_stall (body_stall),
	.body_data  (body_data)
);

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_REPORTS = 40;

	// Predicts the decoded body stream and checks each result item against it.
	class chunked_body_board;
		chbd_pkg::phase_t                 ph;
		logic [1:0]                       crlf_seen;
		logic [chbd_pkg::COUNT_WIDTH-1:0] count;
		chbd_pkg::out_item_t              pending_bodies[$];
		int                               errors;
		int                               data_bytes;
		int                               done_pulses;
		int                               saturations;

		function new();
			errors = 0;
			data_bytes = 0;
			done_pulses = 0;
			saturations = 0;
			restart();
		endfunction

		function void restart();
			ph = chbd_pkg::PH_HEADER;
			crlf_seen = 2'd0;
			count = '0;
		endfunction

		// Hex digit value in either case; letters share the low nibble pattern.
		function logic [4:0] digit_of(logic [7:0] c);
			if (c >= "0" && c <= "9") begin
				return {1'b0, c[3:0]};
			end
			if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
				return 5'(c[3:0] + 4'd9);
			end
			return chbd_pkg::HEX_NONE;
		endfunction

		// Shift in one digit; anything past the counter width pins it at all ones.
		function void add_digit(logic [4:0] d);
			logic [chbd_pkg::COUNT_WIDTH+4:0] grown;
			grown = {1'b0, count, 4'h0} + d;
			if (grown[chbd_pkg::COUNT_WIDTH+4:chbd_pkg::COUNT_WIDTH] != 0) begin
				count = '1;
				saturations++;
			end else begin
				count = grown[chbd_pkg::COUNT_WIDTH-1:0];
			end
		endfunction

		function int pending_count();
			return pending_bodies.size();
		endfunction

		// Called for every accepted byte item.
		function void accept_byte(chbd_pkg::in_item_t it);
			logic [7:0]          b;
			logic                is_crlf;
			logic [4:0]          d;
			chbd_pkg::out_item_t r;
			b = it.in_byte;
			is_crlf = (b == chbd_pkg::CH_CR) || (b == chbd_pkg::CH_LF);
			d = digit_of(b);
			r = '0;
			case (ph)
				chbd_pkg::PH_HEADER: begin
					if (b == (crlf_seen[0] ? chbd_pkg::CH_LF : chbd_pkg::CH_CR)) begin
						if (crlf_seen == 2'd3) begin
							crlf_seen = 2'd0;
							ph = chbd_pkg::PH_SKIP_PRE;
						end else begin
							crlf_seen = crlf_seen + 2'd1;
						end
					end else begin
						crlf_seen = (b == chbd_pkg::CH_CR) ? 2'd1 : 2'd0;
					end
				end
				chbd_pkg::PH_SKIP_PRE: begin
					if (!is_crlf) begin
						count = '0;
						if (d != chbd_pkg::HEX_NONE) begin
							add_digit(d);
							ph = chbd_pkg::PH_SIZE;
						end else begin
							ph = chbd_pkg::PH_DONE;
							r.body_done = 1'b1;
						end
					end
				end
				chbd_pkg::PH_SIZE: begin
					if (d != chbd_pkg::HEX_NONE) begin
						add_digit(d);
					end else if (count == 0) begin
						ph = chbd_pkg::PH_DONE;
						r.body_done = 1'b1;
					end else begin
						ph = chbd_pkg::PH_SKIP_POST;
					end
				end
				chbd_pkg::PH_SKIP_POST, chbd_pkg::PH_DATA: begin
					if (!(ph == chbd_pkg::PH_SKIP_POST && is_crlf)) begin
						r.out_byte = b;
						r.data_valid = 1'b1;
						count = count - 1'b1;
						ph = (count == 0) ? chbd_pkg::PH_SKIP_PRE : chbd_pkg::PH_DATA;
					end
				end
				default: begin
					ph = chbd_pkg::PH_DONE;
				end
			endcase
			// The last byte closes any body still open and re-arms the decoder.
			if (it.in_last) begin
				if (ph != chbd_pkg::PH_DONE) begin
					r.body_done = 1'b1;
				end
				restart();
			end
			pending_bodies.push_back(r);
		endfunction

		function void report(string field, int unsigned want, int unsigned got);
			errors++;
			if (errors <= MAX_REPORTS) begin
				$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			end
		endfunction

		// Called for every accepted result item.
		function void check_body(chbd_pkg::out_item_t got);
			chbd_pkg::out_item_t w;
			if (pending_bodies.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$error("result item arrived with no byte item outstanding");
				end
				return;
			end
			w = pending_bodies.pop_front();
			if (got.out_byte !== w.out_byte) begin
				report("out_byte", w.out_byte, got.out_byte);
			end
			if (got.data_valid !== w.data_valid) begin
				report("data_valid", w.data_valid, got.data_valid);
			end
			if (got.body_done !== w.body_done) begin
				report("body_done", w.body_done, got.body_done);
			end
			if (w.data_valid) begin
				data_bytes++;
			end
			if (w.body_done) begin
				done_pulses++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                byte_valid;
	logic                byte_stall;
	chbd_pkg::in_item_t  byte_data;
	logic                body_valid;
	logic                body_stall;
	chbd_pkg::out_item_t body_data;

	chunked_body_board   board;
	chbd_pkg::in_item_t  byte_q[$];
	int                  sent_count;
	int                  responses;
	int                  send_idle_pct;
	int                  recv_stall_pct;
	int                  cycles = 0;
	int                  hold_left;
	int                  hold_requests;

	http_chunked_body_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_data (byte_data),
		.body_valid(body_valid),
		.body_stall(body_stall),
		.body_data (body_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("http_chunked_body_decoder test failed");
			$finish;
		end
	end

	// Receiver: random stalls, plus each requested long hold counted here.
	initial begin
		int holds_started;
		holds_started = 0;
		hold_left = 0;
		body_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != holds_started) begin
				holds_started = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
			end
			body_stall <= (hold_left > 0) || ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// Result items are checked at the edge that accepts them.
	always @(posedge clk) begin
		if (arst_n && body_valid && !body_stall) begin
			board.check_body(body_data);
		end
	end

	// Offers one byte item and returns at the falling edge after it is accepted.
	task automatic send_byte(chbd_pkg::in_item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= it;
		do begin
			@(posedge clk);
		end while (byte_stall);
		board.accept_byte(it);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic push_byte(logic [7:0] b);
		chbd_pkg::in_item_t it;
		it.in_byte = b;
		it.in_last = 1'b0;
		byte_q.push_back(it);
	endtask

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			push_byte(s[i]);
		end
	endtask

	task automatic push_crlf();
		push_byte(chbd_pkg::CH_CR);
		push_byte(chbd_pkg::CH_LF);
	endtask

	// Hex size line digits in random case, with optional leading zeros.
	task automatic push_size(int unsigned v, int pad);
		logic [7:0] digits[$];
		logic [3:0] nib;
		do begin
			nib = v[3:0];
			if (nib < 10) begin
				digits.push_front(8'h30 + nib);
			end else begin
				digits.push_front(($urandom_range(0, 1) ? 8'h57 : 8'h37) + nib);
			end
			v = v >> 4;
		end while (v != 0);
		repeat (pad) push_byte("0");
		foreach (digits[i]) begin
			push_byte(digits[i]);
		end
	endtask

	// Flags the final byte of the queued response and sends all of it.
	task automatic finish_response();
		byte_q[byte_q.size() - 1].in_last = 1'b1;
		foreach (byte_q[i]) begin
			send_byte(byte_q[i]);
		end
		byte_q.delete();
		responses++;
	endtask

	task automatic directed_responses();
		// Header end found after a broken match, a size ended by a non-hex byte,
		// data holding CR, then an empty size line and ignored bytes.
		push_byte(chbd_pkg::CH_CR);
		push_byte(chbd_pkg::CH_CR);
		push_byte(chbd_pkg::CH_LF);
		push_crlf();
		push_byte(chbd_pkg::CH_LF);
		push_text("2;");
		push_byte(chbd_pkg::CH_LF);
		push_byte(8'h00);
		push_byte(chbd_pkg::CH_CR);
		push_text("gQ");
		push_byte(8'hff);
		finish_response();
		// Mixed-case size that overflows the counter; input ends mid-chunk.
		push_crlf();
		push_crlf();
		push_text("aFFFFFFFF");
		push_byte(chbd_pkg::CH_LF);
		push_byte(8'h80);
		finish_response();
		// Input ends while still searching for the header end.
		push_byte(8'h7f);
		finish_response();
	endtask

	// One random response: mostly well formed, some cut short, some pure noise.
	task automatic random_response();
		int kind;
		int sz;
		int cut;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(0, 16)) begin
				if ($urandom_range(0, 7) == 0) begin
					push_crlf();
				end else if ($urandom_range(0, 7) == 0) begin
					push_byte(8'($urandom_range(0, 255)));
				end else begin
					push_byte(8'($urandom_range(32, 126)));
				end
			end
			push_crlf();
			push_crlf();
			repeat ($urandom_range(0, 4)) begin
				if ($urandom_range(0, 3) == 0) begin
					push_byte($urandom_range(0, 1) ? chbd_pkg::CH_CR : chbd_pkg::CH_LF);
				end
				sz = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48)
				                                 : $urandom_range(1, 12);
				push_size(sz, $urandom_range(0, 2));
				case ($urandom_range(0, 3))
					0: push_crlf();
					1: push_byte(chbd_pkg::CH_LF);
					2: push_text(";");
					default: begin
						push_byte(chbd_pkg::CH_CR);
						push_crlf();
					end
				endcase
				repeat (sz) push_byte(8'($urandom_range(0, 255)));
				push_crlf();
			end
			// Usually a zero chunk; now and then an empty size line instead.
			if ($urandom_range(0, 9) == 0) begin
				push_byte($urandom_range(0, 1) ? "x" : ";");
			end else begin
				push_size(0, $urandom_range(0, 2));
				push_crlf();
				push_crlf();
			end
			repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 255)));
			if (kind <= 2) begin
				cut = $urandom_range(1, byte_q.size());
				while (byte_q.size() > cut) begin
					void'(byte_q.pop_back());
				end
			end
		end
		finish_response();
	endtask

	// Sender stops offering until every predicted result has been checked.
	task automatic wait_drained();
		byte_valid <= 1'b0;
		while (board.pending_count() != 0) begin
			@(negedge clk);
		end
	endtask

	initial begin
		int phase_end[3];
		board = new();
		sent_count = 0;
		responses = 0;
		hold_requests = 0;
		send_idle_pct = 6;
		recv_stall_pct = 58;
		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_data = '0;
		phase_end[0] = 430;
		phase_end[1] = 830;
		phase_end[2] = 1230;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed_responses();

		// Three idling phases: sender light, then receiver light, then none but one long receiver hold.
		for (int p = 0; p < 3; p++) begin
			send_idle_pct = (p == 0) ? 6 : ((p == 1) ? 58 : 0);
			recv_stall_pct = (p == 0) ? 58 : ((p == 1) ? 6 : 0);
			if (p == 2) begin
				hold_requests++;
			end
			while (sent_count < phase_end[p]) begin
				random_response();
			end
			wait_drained();
		end

		repeat (4) @(posedge clk);
		if (board.pending_count() != 0) begin
			board.errors++;
			$error("%0d result items never arrived", board.pending_count());
		end
		$display("Sent %0d responses in %0d byte items; checked %0d body bytes and %0d body ends.",
			responses, sent_count, board.data_bytes, board.done_pulses);
		$display("Size overflow hit %0d times; idling varied on both sides with one long hold.",
			board.saturations);
		if (board.errors == 0) begin
			$display("http_chunked_body_decoder test passed");
		end else begin
			$display("http_chunked_body_decoder test failed");
		end
		$finish;
	end

endmodule
